@@ hw/rtl/single_float_add_sub_assert.svh @@
// Assertion macros for the single-precision adder.
`ifndef SINGLE_FLOAT_ADD_SUB_ASSERT_SVH
`define SINGLE_FLOAT_ADD_SUB_ASSERT_SVH
`ifndef ASSERT_OFF
`define SFA_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define SFA_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define SFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/sfa_pkg.sv @@
// Package of shared types and constants for the single-precision adder.
`timescale 1ns / 1ps
package sfa_pkg;
    localparam int unsigned ExpW = 8;
    localparam int unsigned MantW = 24;
    localparam logic [ExpW-1:0] ExpMax = 8'hFF;

    typedef struct packed {
        logic            special;
        logic [31:0]     special_bits;
        logic            eff_sub;
        logic            sign;
        logic [ExpW-1:0] exp;
        logic [MantW-1:0] big;
        logic [MantW-1:0] sml;
        logic            dec;
    } t_align;

    typedef struct packed {
        logic            special;
        logic [31:0]     special_bits;
        logic            sign;
        logic [9:0]      exp;
        logic [MantW:0]  mant;
    } t_sum;
endpackage

@@ hw/rtl/sfa_align.sv @@
// Unpack, zero handling, operand ordering and alignment shift.
`timescale 1ns / 1ps
module sfa_align (
    input  logic        i_func,
    input  logic [31:0] i_a_bits,
    input  logic [31:0] i_b_bits,
    output sfa_pkg::t_align o_align
);
    logic       sa, sb, za, zb, a_big;
    logic [7:0] ea, eb, d;
    logic [23:0] ma, mb, mbig, msml;
    logic [7:0] diff;

    always_comb begin
        sa = i_a_bits[31];
        sb = i_b_bits[31] ^ i_func;
        ea = i_a_bits[30:23];
        eb = i_b_bits[30:23];
        ma = {1'b1, i_a_bits[22:0]};
        mb = {1'b1, i_b_bits[22:0]};
        za = (i_a_bits[30:0] == 31'd0);
        zb = (i_b_bits[30:0] == 31'd0);
        diff = ea - eb;
        a_big = (ea > eb) || ((ea == eb) && (ma >= mb));
        mbig = a_big ? ma : mb;
        msml = a_big ? mb : ma;
        d = a_big ? diff : (8'd0 - diff);
        o_align = '0;
        o_align.eff_sub = (sa != sb);
        o_align.sign = a_big ? sa : sb;
        o_align.exp = a_big ? ea : eb;
        o_align.big = mbig;
        o_align.sml = (d >= 8'd24) ? 24'd0 : (msml >> d[4:0]);
        o_align.dec = (d != 8'd0) && (d <= 8'd24) && msml[5'(d - 8'd1)];
        if (za && zb) begin
            o_align.special = 1'b1;
            o_align.special_bits = 32'd0;
        end else if (za) begin
            o_align.special = 1'b1;
            o_align.special_bits = {sb, i_b_bits[30:0]};
        end else if (zb) begin
            o_align.special = 1'b1;
            o_align.special_bits = i_a_bits;
        end else if (sa != sb && ea == eb && ma == mb) begin
            o_align.special = 1'b1;
            o_align.special_bits = 32'd0;
        end
    end
endmodule

@@ hw/rtl/sfa_addsub.sv @@
// Mantissa add or subtract with carry shift.
`timescale 1ns / 1ps
module sfa_addsub (
    input  sfa_pkg::t_align i_align,
    output sfa_pkg::t_sum   o_sum
);
    logic [24:0] m;

    always_comb begin
        if (i_align.eff_sub) begin
            m = {1'b0, i_align.big} - {24'd0, i_align.dec} - {1'b0, i_align.sml};
        end else begin
            m = {1'b0, i_align.big} + {1'b0, i_align.sml};
        end
        o_sum.special = i_align.special;
        o_sum.special_bits = i_align.special_bits;
        o_sum.sign = i_align.sign;
        if (!i_align.eff_sub && m[24]) begin
            o_sum.mant = {1'b0, m[24:1]};
            o_sum.exp = {2'b00, i_align.exp} + 10'd1;
        end else begin
            o_sum.mant = m;
            o_sum.exp = {2'b00, i_align.exp};
        end
    end
endmodule

@@ hw/rtl/sfa_norm.sv @@
// Leading-zero normalisation, range check and packing.
`timescale 1ns / 1ps
module sfa_norm (
    input  sfa_pkg::t_sum i_sum,
    output logic [31:0]   o_result_bits,
    output logic          o_overflow,
    output logic          o_underflow
);
    logic [4:0]  lz;
    logic [23:0] m;
    logic [9:0]  e;

    always_comb begin
        lz = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (i_sum.mant[i]) begin
                lz = 5'(23 - i);
            end
        end
        m = i_sum.mant[23:0] << lz;
        e = i_sum.exp - {5'd0, lz};
        o_overflow = 1'b0;
        o_underflow = 1'b0;
        if (i_sum.special) begin
            o_result_bits = i_sum.special_bits;
        end else if (i_sum.mant == 25'd0) begin
            o_result_bits = {i_sum.sign, 31'd0};
            o_underflow = 1'b1;
        end else if (!e[9] && e > 10'd254) begin
            o_result_bits = {i_sum.sign, sfa_pkg::ExpMax, 23'd0};
            o_overflow = 1'b1;
        end else if (e[9] || e == 10'd0) begin
            o_result_bits = {i_sum.sign, 31'd0};
            o_underflow = 1'b1;
        end else begin
            o_result_bits = {i_sum.sign, e[7:0], m[22:0]};
        end
    end
endmodule

@@ hw/rtl/single_float_add_sub.sv @@
// Top level: three-stage single-precision add and subtract pipeline.
// start is registered through r_v1, r_v2 and r_v3 to o_done; one item accepted every cycle.
// busy is always low: align, add and normalise stages each hold one item.
// Synchronous active-low reset clears the stage valid bits; no results follow.
// The receiver cannot stall; each result shows for one cycle with o_done.
`timescale 1ns / 1ps
`include "single_float_add_sub_assert.svh"
module single_float_add_sub (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [31:0] i_a_bits,
    input  logic [31:0] i_b_bits,
    output logic        o_done,
    output logic [31:0] o_result_bits,
    output logic        o_overflow,
    output logic        o_underflow
);
    sfa_pkg::t_align n_align, r_align;
    sfa_pkg::t_sum   n_sum, r_sum;
    logic [31:0] n_res;
    logic        n_ovf, n_unf;
    logic        r_v1, r_v2, r_v3;
    logic [31:0] r_res;
    logic        r_ovf, r_unf;

    assign busy = 1'b0;

    sfa_align u_align (.i_func(i_func), .i_a_bits(i_a_bits), .i_b_bits(i_b_bits),
                       .o_align(n_align));
    sfa_addsub u_addsub (.i_align(r_align), .o_sum(n_sum));
    sfa_norm u_norm (.i_sum(r_sum), .o_result_bits(n_res), .o_overflow(n_ovf),
                     .o_underflow(n_unf));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_align <= n_align;
        r_sum <= n_sum;
        r_res <= n_res;
        r_ovf <= n_ovf;
        r_unf <= n_unf;
    end

    assign o_done = r_v3;
    assign o_result_bits = r_res;
    assign o_overflow = r_ovf;
    assign o_underflow = r_unf;

    `SFA_ASSERT_IMPL(a_flags_excl, i_clk, i_rst_n, !(o_done && o_overflow && o_underflow), "both flags set")
    `SFA_ASSERT_NEXT(a_v_flow, i_clk, i_rst_n, r_v1, r_v2, "stage valid lost")
    `SFA_ASSERT_IMPL(a_ovf_inf, i_clk, i_rst_n, !(o_done && o_overflow) || (o_result_bits[30:0] == 31'h7F800000), "overflow not infinity")
endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the single-precision add and subtract pipeline.
`timescale 1ns / 1ps
class fadd_scoreboard;
    logic [33:0] sums_q[$];
    int unsigned mismatches;

    function automatic logic [33:0] compute_sum(logic sub, logic [31:0] a, logic [31:0] b);
        logic        sa, sb, s;
        logic [7:0]  ea, eb;
        logic [31:0] ma, mb, m, sh;
        int          e, d;
        sa = a[31];
        sb = b[31] ^ sub;
        ea = a[30:23];
        eb = b[30:23];
        ma = {9'd0, a[22:0]};
        mb = {9'd0, b[22:0]};
        if (ea == 0 && ma == 0 && eb == 0 && mb == 0) return 34'd0;
        if (ea == 0 && ma == 0) return {2'b00, sb, eb, mb[22:0]};
        if (eb == 0 && mb == 0) return {2'b00, sa, ea, ma[22:0]};
        ma[23] = 1'b1;
        mb[23] = 1'b1;
        if (sa == sb) begin
            s = sa;
            if (ea >= eb) begin
                e = ea;
                d = ea - eb;
                sh = (d >= 32) ? 32'd0 : (mb >> d);
                m = ma + sh;
            end else begin
                e = eb;
                d = eb - ea;
                sh = (d >= 32) ? 32'd0 : (ma >> d);
                m = mb + sh;
            end
            if (m[24]) begin
                m = m >> 1;
                e = e + 1;
            end
        end else begin
            if (ea > eb) begin
                s = sa;
                e = ea;
                d = ea - eb;
                if (d <= 32 && mb[d-1]) ma = ma - 1;
                sh = (d >= 32) ? 32'd0 : (mb >> d);
                m = ma - sh;
            end else if (ea < eb) begin
                s = sb;
                e = eb;
                d = eb - ea;
                if (d <= 32 && ma[d-1]) mb = mb - 1;
                sh = (d >= 32) ? 32'd0 : (ma >> d);
                m = mb - sh;
            end else begin
                e = ea;
                if (ma == mb) return 34'd0;
                if (ma > mb) begin
                    s = sa;
                    m = ma - mb;
                end else begin
                    s = sb;
                    m = mb - ma;
                end
            end
            if (m == 0) return {2'b01, s, 31'd0};
            while (!m[23]) begin
                m = m << 1;
                e = e - 1;
            end
        end
        if (e > 254) return {2'b10, s, 8'hFF, 23'd0};
        if (e < 1) return {2'b01, s, 31'd0};
        return {2'b00, s, e[7:0], m[22:0]};
    endfunction

    function void note_operands(logic sub, logic [31:0] a, logic [31:0] b);
        sums_q.push_back(compute_sum(sub, a, b));
    endfunction

    function void check_sum(logic [31:0] bits, logic ovf, logic unf);
        logic [33:0] exp_sum;
        if (sums_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", bits);
            return;
        end
        exp_sum = sums_q.pop_front();
        if (exp_sum != {ovf, unf, bits}) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %h ovf %b unf %b, got %h ovf %b unf %b",
                         exp_sum[31:0], exp_sum[33], exp_sum[32], bits, ovf, unf);
        end
    endfunction
endclass

module tb_top;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_func = 1'b0;
    logic [31:0] i_a_bits = '0;
    logic [31:0] i_b_bits = '0;
    logic        o_done;
    logic [31:0] o_result_bits;
    logic        o_overflow;
    logic        o_underflow;

    fadd_scoreboard board = new();

    single_float_add_sub u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_a_bits(i_a_bits), .i_b_bits(i_b_bits),
        .o_done(o_done), .o_result_bits(o_result_bits),
        .o_overflow(o_overflow), .o_underflow(o_underflow)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) board.note_operands(i_func, i_a_bits, i_b_bits);
        if (i_rst_n && o_done) board.check_sum(o_result_bits, o_overflow, o_underflow);
    end

    // hold start until accepted; gaps drawn per item
    task automatic send_operands(logic sub, logic [31:0] a, logic [31:0] b, bit gappy);
        int gap;
        gap = gappy ? $urandom_range(0, 16) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_func <= sub;
        i_a_bits <= a;
        i_b_bits <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_operand();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0: w[30:0] = 31'd0;
            1: w[30:23] = 8'hFF;
            2: w[30:23] = 8'h00;
            3: w[30:23] = 8'($urandom_range(1, 3));
            4: w[30:23] = 8'($urandom_range(250, 254));
            default: w[30:23] = 8'($urandom_range(100, 154));
        endcase
        return w;
    endfunction

    initial begin
        logic [31:0] a, b;
        int n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_operands(1'b0, 32'h0000_0000, 32'h8000_0000, 0);
        send_operands(1'b1, 32'h0000_0000, 32'h3F80_0000, 0);
        send_operands(1'b0, 32'hC040_0000, 32'h0000_0000, 0);
        send_operands(1'b1, 32'h3F80_0000, 32'h3F80_0000, 0);
        send_operands(1'b0, 32'h3F80_0000, 32'hBF80_0000, 0);
        send_operands(1'b0, 32'h3FC0_0000, 32'hBF80_0000, 0);
        send_operands(1'b1, 32'h3F80_0001, 32'h3F80_0000, 0);
        send_operands(1'b0, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 0);
        send_operands(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_operands(1'b1, 32'h0080_0001, 32'h0080_0000, 0);
        send_operands(1'b1, 32'h0080_0000, 32'h0000_0001, 0);
        send_operands(1'b0, 32'h4B80_0000, 32'h8000_0001, 0);
        send_operands(1'b1, 32'h4F80_0000, 32'h3F80_0000, 0);
        send_operands(1'b1, 32'h7F80_0000, 32'h0080_0000, 0);
        send_operands(1'b0, 32'h3F80_0000, 32'hB3FF_FFFF, 0);
        send_operands(1'b1, 32'h3F80_0000, 32'h3380_0000, 0);
        send_operands(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_operands(1'b1, 32'h4000_0000, 32'h3FFF_FFFF, 0);
        for (n = 0; n < 700; n++) begin
            a = rand_operand();
            b = rand_operand();
            if ($urandom_range(0, 4) == 0) b[30:23] = a[30:23];
            if ($urandom_range(0, 9) == 0) b[30:0] = a[30:0];
            send_operands(1'($urandom_range(0, 1)), a, b, (n / 100) % 2 == 0);
        end
        start <= 1'b0;
        n = 0;
        while (board.sums_q.size() != 0 && n < 1000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (10) @(posedge i_clk);
        if (board.mismatches == 0 && board.sums_q.size() == 0) begin
            $display("single_float_add_sub regression: pass");
        end else begin
            $display("single_float_add_sub regression: fail");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("single_float_add_sub regression: fail");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/sfa_pkg.sv
hw/rtl/sfa_align.sv
hw/rtl/sfa_addsub.sv
hw/rtl/sfa_norm.sv
hw/rtl/single_float_add_sub.sv
verif/tb_top.sv
